// ===== design/s5hp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s5hp_pkg;

  // Parser phases, one-hot
  typedef enum logic [12:0] {
    PH_GREET_VER   = 13'b0000000000001,
    PH_GREET_COUNT = 13'b0000000000010,
    PH_GREET_LIST  = 13'b0000000000100,
    PH_REQ_VER     = 13'b0000000001000,
    PH_REQ_CMD     = 13'b0000000010000,
    PH_REQ_RSV     = 13'b0000000100000,
    PH_REQ_ATYP    = 13'b0000001000000,
    PH_DOM_LEN     = 13'b0000010000000,
    PH_ADDR        = 13'b0000100000000,
    PH_PORT_HI     = 13'b0001000000000,
    PH_PORT_LO     = 13'b0010000000000,
    PH_OPEN        = 13'b0100000000000,
    PH_FAILED      = 13'b1000000000000
  } phase_t;

  // Event codes on event_res
  localparam logic [2:0] EV_MORE    = 3'd0;
  localparam logic [2:0] EV_AUTH    = 3'd1;
  localparam logic [2:0] EV_CONNECT = 3'd2;
  localparam logic [2:0] EV_ERROR   = 3'd3;
  localparam logic [2:0] EV_PAYLOAD = 3'd4;

  // Address kinds on addr_type
  localparam logic [1:0] KIND_IPV4   = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_IPV6   = 2'd2;

  // Protocol byte codes
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] LEN_IPV4      = 8'd4;
  localparam logic [7:0] LEN_IPV6      = 8'd16;

endpackage

`default_nettype wire

// ===== design/socks5_handshake_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SOCKS5 greeting and CONNECT request parser, one client byte per beat.
// Input channel: in_valid / in_stall with data_byte and conn_start; a beat
// with conn_start set restarts the parser and is parsed as the first byte of
// a new connection. Output channel: out_valid / out_stall with one result per
// input beat: event_res, addr_type, addr_byte, addr_valid, addr_length and
// target_port. Configuration: cfg_wr_en / cfg_wr_data write the accepted
// authentication method; write it only while no beat is in flight.
// A beat accepted into the input register is parsed combinationally by the
// phase machine, and its result is captured in the result register when that
// stage advances.
// Throughput: one byte per cycle unless the receiver stalls; the parse is a single
// pass of the phase machine between the input register and the result register.
// Reset (rst, synchronous): parser returns to the greeting version phase,
// the accepted method clears to 0, both stages empty.
// When the receiver stalls, the result holds, the input register fills, and
// in_stall rises only once both stages are occupied.

module socks5_handshake_parser_core (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       conn_start,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [1:0]      addr_type,
  output logic [7:0]      addr_byte,
  output logic            addr_valid,
  output logic [7:0]      addr_length,
  output logic [15:0]     target_port
);

  logic                 advance;
  logic [7:0]           accepted_method;

  // input register
  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 hold_start;

  // parser state
  s5hp_pkg::phase_t     phase;
  logic [7:0]           byte_count;
  logic [7:0]           method_total;
  logic                 method_found;
  logic [1:0]           kind_of_address;
  logic [7:0]           address_size;
  logic [15:0]          port_value;

  s5hp_pkg::phase_t     phase_next;
  logic [7:0]           byte_count_next;
  logic [7:0]           method_total_next;
  logic                 method_found_next;
  logic [1:0]           kind_of_address_next;
  logic [7:0]           address_size_next;
  logic [15:0]          port_value_next;
  logic [2:0]           event_next;
  logic                 valid_next;
  logic [7:0]           count_inc;

  // result stage moves when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;

  // accepted method register
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_method <= 8'd0;
    end else if (cfg_wr_en) begin
      accepted_method <= cfg_wr_data;
    end
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte  <= data_byte;
      hold_start <= conn_start;
    end
  end

  // parse one byte
  always_comb begin
    s5hp_pkg::phase_t cur_phase;
    logic [7:0]       cur_count;
    logic [7:0]       cur_total;
    logic             cur_found;
    logic [1:0]       cur_kind;
    logic [7:0]       cur_size;
    logic [15:0]      cur_port;

    // restart on a new connection
    if (hold_start) begin
      cur_phase = s5hp_pkg::PH_GREET_VER;
      cur_count = 8'd0;
      cur_total = 8'd0;
      cur_found = 1'b0;
      cur_kind  = s5hp_pkg::KIND_IPV4;
      cur_size  = 8'd0;
      cur_port  = 16'd0;
    end else begin
      cur_phase = phase;
      cur_count = byte_count;
      cur_total = method_total;
      cur_found = method_found;
      cur_kind  = kind_of_address;
      cur_size  = address_size;
      cur_port  = port_value;
    end

    phase_next           = cur_phase;
    byte_count_next      = cur_count;
    method_total_next    = cur_total;
    method_found_next    = cur_found;
    kind_of_address_next = cur_kind;
    address_size_next    = cur_size;
    port_value_next      = cur_port;
    event_next           = s5hp_pkg::EV_MORE;
    valid_next           = 1'b0;
    count_inc            = cur_count + 8'd1;

    unique case (cur_phase)
      s5hp_pkg::PH_GREET_VER: begin
        if (hold_byte == s5hp_pkg::SOCKS_VERSION) begin
          phase_next = s5hp_pkg::PH_GREET_COUNT;
        end else begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end
      end
      s5hp_pkg::PH_GREET_COUNT: begin
        method_total_next = hold_byte;
        byte_count_next   = 8'd0;
        method_found_next = 1'b0;
        if (hold_byte == 8'd0) begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end else begin
          phase_next = s5hp_pkg::PH_GREET_LIST;
        end
      end
      s5hp_pkg::PH_GREET_LIST: begin
        if (hold_byte == accepted_method) begin
          method_found_next = 1'b1;
        end
        byte_count_next = count_inc;
        // end of method list
        if (count_inc == cur_total) begin
          if (cur_found || hold_byte == accepted_method) begin
            phase_next = s5hp_pkg::PH_REQ_VER;
            event_next = s5hp_pkg::EV_AUTH;
          end else begin
            phase_next = s5hp_pkg::PH_FAILED;
            event_next = s5hp_pkg::EV_ERROR;
          end
        end
      end
      s5hp_pkg::PH_REQ_VER: begin
        if (hold_byte == s5hp_pkg::SOCKS_VERSION) begin
          phase_next = s5hp_pkg::PH_REQ_CMD;
        end else begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end
      end
      s5hp_pkg::PH_REQ_CMD: begin
        if (hold_byte == s5hp_pkg::CMD_CONNECT) begin
          phase_next = s5hp_pkg::PH_REQ_RSV;
        end else begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end
      end
      s5hp_pkg::PH_REQ_RSV: begin
        if (hold_byte == 8'd0) begin
          phase_next = s5hp_pkg::PH_REQ_ATYP;
        end else begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end
      end
      s5hp_pkg::PH_REQ_ATYP: begin
        byte_count_next = 8'd0;
        priority if (hold_byte == s5hp_pkg::ATYP_IPV4) begin
          kind_of_address_next = s5hp_pkg::KIND_IPV4;
          address_size_next    = s5hp_pkg::LEN_IPV4;
          phase_next           = s5hp_pkg::PH_ADDR;
        end else if (hold_byte == s5hp_pkg::ATYP_DOMAIN) begin
          kind_of_address_next = s5hp_pkg::KIND_DOMAIN;
          phase_next           = s5hp_pkg::PH_DOM_LEN;
        end else if (hold_byte == s5hp_pkg::ATYP_IPV6) begin
          kind_of_address_next = s5hp_pkg::KIND_IPV6;
          address_size_next    = s5hp_pkg::LEN_IPV6;
          phase_next           = s5hp_pkg::PH_ADDR;
        end else begin
          phase_next = s5hp_pkg::PH_FAILED;
          event_next = s5hp_pkg::EV_ERROR;
        end
      end
      s5hp_pkg::PH_DOM_LEN: begin
        address_size_next = hold_byte;
        byte_count_next   = 8'd0;
        // empty domain goes straight to the port
        phase_next = (hold_byte == 8'd0) ? s5hp_pkg::PH_PORT_HI : s5hp_pkg::PH_ADDR;
      end
      s5hp_pkg::PH_ADDR: begin
        valid_next      = 1'b1;
        byte_count_next = count_inc;
        if (count_inc == cur_size) begin
          phase_next = s5hp_pkg::PH_PORT_HI;
        end
      end
      s5hp_pkg::PH_PORT_HI: begin
        port_value_next = {hold_byte, 8'd0};
        phase_next      = s5hp_pkg::PH_PORT_LO;
      end
      s5hp_pkg::PH_PORT_LO: begin
        port_value_next = {cur_port[15:8], cur_port[7:0] | hold_byte};
        phase_next      = s5hp_pkg::PH_OPEN;
        event_next      = s5hp_pkg::EV_CONNECT;
      end
      s5hp_pkg::PH_OPEN: begin
        event_next = s5hp_pkg::EV_PAYLOAD;
      end
      default: begin
        // failed: hold until the next connection start
        phase_next = s5hp_pkg::PH_FAILED;
        event_next = s5hp_pkg::EV_ERROR;
      end
    endcase
  end

  // update parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      phase           <= s5hp_pkg::PH_GREET_VER;
      byte_count      <= 8'd0;
      method_total    <= 8'd0;
      method_found    <= 1'b0;
      kind_of_address <= s5hp_pkg::KIND_IPV4;
      address_size    <= 8'd0;
      port_value      <= 16'd0;
    end else if (advance) begin
      out_valid <= hold_valid;
      if (hold_valid) begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        method_total    <= method_total_next;
        method_found    <= method_found_next;
        kind_of_address <= kind_of_address_next;
        address_size    <= address_size_next;
        port_value      <= port_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      event_res   <= event_next;
      addr_type   <= kind_of_address_next;
      addr_byte   <= valid_next ? hold_byte : 8'd0;
      addr_valid  <= valid_next;
      addr_length <= address_size_next;
      target_port <= (event_next == s5hp_pkg::EV_CONNECT ||
                      event_next == s5hp_pkg::EV_PAYLOAD) ? port_value_next : 16'd0;
    end
  end

endmodule

`default_nettype wire
